@@ rtl/tkp_pkg.sv @@
// Package for the two-key press classifier: event codes, register indexes,
// lane flag struct and reset values of the threshold registers.
// No dependencies.
package tkp_pkg;

    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int EVENT_W   = 3;

    localparam logic [TICK_W-1:0] SHORT_TICKS_RST = 16'd2;
    localparam logic [TICK_W-1:0] LONG_TICKS_RST  = 16'd300;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS  = 2'd1;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 3'd0,
        EV_K1_SHORT = 3'd1,
        EV_K2_SHORT = 3'd2,
        EV_COMBO    = 3'd3,
        EV_K1_LONG  = 3'd4,
        EV_K2_LONG  = 3'd5
    } event_code_t;

    // What one key lane found in the current tick.
    typedef struct packed {
        logic short_hit;
        logic long_hit;
    } lane_evt_t;

endpackage

@@ rtl/tkp_key_lane.sv @@
// One key lane: hold counter, pending flag and lock for a single key.
// Depends on tkp_pkg.
module tkp_key_lane
    import tkp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              released,
    input  logic [TICK_W-1:0] short_ticks,
    input  logic [TICK_W-1:0] long_ticks,
    output lane_evt_t         evt
);

    localparam int CMP_W = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;

    logic [COUNT_WIDTH-1:0] count_reg, count_next, count_inc;
    logic                   locked_reg, locked_next;
    logic                   pending_reg, pending_next;
    logic [CMP_W-1:0]       inc_wide, short_wide, long_wide;

    assign count_inc  = count_reg + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    assign inc_wide   = CMP_W'(count_inc);
    assign short_wide = CMP_W'(short_ticks);
    assign long_wide  = CMP_W'(long_ticks);

    always_comb
    begin
        count_next   = count_reg;
        locked_next  = locked_reg;
        pending_next = pending_reg;
        evt          = '0;
        if (released)
        begin
            count_next    = '0;
            locked_next   = 1'b0;
            pending_next  = 1'b0;
            evt.short_hit = pending_reg;
        end
        else if (!locked_reg)
        begin
            count_next = count_inc;
            if (inc_wide > short_wide)
            begin
                pending_next = 1'b1;
            end
            if (inc_wide > long_wide)
            begin
                pending_next = 1'b0;
                count_next   = '0;
                locked_next  = 1'b1;
                evt.long_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            locked_reg  <= 1'b0;
            pending_reg <= 1'b0;
        end
        else if (advance)
        begin
            count_reg   <= count_next;
            locked_reg  <= locked_next;
            pending_reg <= pending_next;
        end
    end

endmodule

@@ rtl/tkp_combo_lane.sv @@
// Combo lane: saturating counter and pending flag for both keys held.
// Depends on tkp_pkg.
module tkp_combo_lane
    import tkp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              key1_released,
    input  logic              key2_released,
    input  logic [TICK_W-1:0] short_ticks,
    output logic              combo_hit
);

    localparam int CMP_W = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   pending_reg, pending_next;

    always_comb
    begin
        count_next   = count_reg;
        pending_next = pending_reg;
        combo_hit    = 1'b0;
        if (key1_released || key2_released)
        begin
            count_next   = '0;
            pending_next = 1'b0;
            combo_hit    = pending_reg;
        end
        else
        begin
            // saturate instead of wrapping
            if (count_reg != {COUNT_WIDTH{1'b1}})
            begin
                count_next = count_reg + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
            end
            if (CMP_W'(count_next) > CMP_W'(short_ticks))
            begin
                pending_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            pending_reg <= 1'b0;
        end
        else if (advance)
        begin
            count_reg   <= count_next;
            pending_reg <= pending_next;
        end
    end

endmodule

@@ rtl/tkp_merge.sv @@
// Merge stage: folds the lane findings into one event code, later lanes win.
// Depends on tkp_pkg.
module tkp_merge
    import tkp_pkg::*;
(
    input  lane_evt_t   key1_evt,
    input  lane_evt_t   key2_evt,
    input  logic        combo_hit,
    output event_code_t code
);

    always_comb
    begin
        priority if (combo_hit)
            code = EV_COMBO;
        else if (key2_evt.long_hit)
            code = EV_K2_LONG;
        else if (key2_evt.short_hit)
            code = EV_K2_SHORT;
        else if (key1_evt.long_hit)
            code = EV_K1_LONG;
        else if (key1_evt.short_hit)
            code = EV_K1_SHORT;
        else
            code = EV_NONE;
    end

endmodule

@@ rtl/two_key_press_classifier_top.sv @@
// Top level of the two-key press classifier: config registers, three lanes,
// merge stage and output register with skid. Depends on tkp_pkg, the lanes and tkp_merge.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------------
//   in      | input     | in_valid / in_stall      | key1_released, key2_released
//   out     | output    | out_valid / out_stall    | event_code
//   cfg     | input     | cfg_we (no handshake)    | cfg_index, cfg_wdata
//
// One scan tick per cycle while in_stall is low: every lane updates its state in the cycle the
// request is accepted; its event code goes to the output register, or to the skid if held.
// The output register plus a one-entry skid let a new request in while a
// result waits; in_stall rises only when both hold a result.
// Reset clears all lane state and loads the threshold defaults.
module two_key_press_classifier_top
    import tkp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 key1_released,
    input  logic                 key2_released,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [EVENT_W-1:0]   event_code,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_wdata
);

    logic [TICK_W-1:0] short_ticks_reg;
    logic [TICK_W-1:0] long_ticks_reg;

    logic        accept;
    logic        take_out;
    lane_evt_t   key1_evt, key2_evt;
    logic        combo_hit;
    event_code_t new_code;

    logic        out_valid_reg;
    event_code_t out_code_reg;
    logic        skid_valid_reg;
    event_code_t skid_code_reg;

    // Threshold registers; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_ticks_reg <= SHORT_TICKS_RST;
            long_ticks_reg  <= LONG_TICKS_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_SHORT_TICKS)
            begin
                short_ticks_reg <= cfg_wdata;
            end
            if (cfg_index == CFG_LONG_TICKS)
            begin
                long_ticks_reg <= cfg_wdata;
            end
        end
    end

    // Stall the input only while the skid entry is occupied.
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign take_out = out_valid_reg && !out_stall;

    tkp_key_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_key1 (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (accept),
        .released    (key1_released),
        .short_ticks (short_ticks_reg),
        .long_ticks  (long_ticks_reg),
        .evt         (key1_evt)
    );

    tkp_key_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_key2 (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (accept),
        .released    (key2_released),
        .short_ticks (short_ticks_reg),
        .long_ticks  (long_ticks_reg),
        .evt         (key2_evt)
    );

    tkp_combo_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_combo (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (accept),
        .key1_released (key1_released),
        .key2_released (key2_released),
        .short_ticks   (short_ticks_reg),
        .combo_hit     (combo_hit)
    );

    // Key one first, then key two, then the combo: the last event wins.
    tkp_merge u_merge (
        .key1_evt  (key1_evt),
        .key2_evt  (key2_evt),
        .combo_hit (combo_hit),
        .code      (new_code)
    );

    // Output register and skid control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || take_out)
        begin
            // Output slot frees up: drain the skid first, else load the new result.
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            // Output held by the consumer: park the new result.
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take_out)
        begin
            out_code_reg <= skid_valid_reg ? skid_code_reg : new_code;
        end
        if (out_valid_reg && !take_out && accept)
        begin
            skid_code_reg <= new_code;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_code = out_code_reg;

endmodule

@@ rtl/tkp_checker.sv @@
// Port-level checker for the two-key press classifier, bound to the top.
// Depends on tkp_pkg.
module tkp_checker
    import tkp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [EVENT_W-1:0] event_code
);

    // A held result stays put until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_code))
        else $error("stalled result changed or dropped");

    // Only codes up to key2 long press are ever produced.
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_code <= EVENT_W'(EV_K2_LONG))
        else $error("event code out of range");

    // Input stalls only while a result is waiting at the output.
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // The skid fills only from an accepted request behind a stalled output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall && in_valid))
        else $error("input stall raised without cause");

endmodule

bind two_key_press_classifier_top tkp_checker u_tkp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_code (event_code)
);
